FILE: hw/rtl/rrts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants for the round-robin thread scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

    // Width of a thread index and of the thread count register
    localparam int IDX_W      = 6;
    localparam int TC_W       = 6;
    localparam int TICKS_W    = 32;
    localparam int FLAGS_W    = 32;
    // Cells per priority group in the cell row
    localparam int GROUP_SIZE = 8;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SCHED = 2'd1,
        OP_DELAY = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_OUT
    } t_state;

    // Per-cycle commands broadcast to every cell
    typedef struct packed {
        logic tick;
        logic load;
        logic cfg_wr;
    } t_cell_ctrl;

endpackage
`default_nettype wire

FILE: hw/rtl/rrts_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_cell
// One user thread: timeout counter, ready bit and a link of the in-group
// priority chain that finds the first requesting cell.
// ----------------------------------------------------------------------------
module rrts_cell #(
    parameter int IDX           = 0,
    parameter int TIMEOUT_WIDTH = 32
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  rrts_pkg::t_cell_ctrl      i_ctrl,
    input  wire [TIMEOUT_WIDTH-1:0]   i_ticks,
    input  wire [rrts_pkg::IDX_W-1:0] i_cur,
    input  wire                       i_act,
    input  wire                       i_act_new,
    input  wire                       i_seen_up,
    input  wire                       i_seen_all,
    output logic                      o_seen_up,
    output logic                      o_seen_all,
    output logic                      o_hit_up,
    output logic                      o_hit_all,
    output logic                      o_ready
);
    import rrts_pkg::*;

    logic [TIMEOUT_WIDTH-1:0] r_cnt;
    logic                     r_ready;
    logic                     w_sel;
    logic                     w_req_all;
    logic                     w_req_up;

    // This cell is the current thread's slot
    assign w_sel = (i_cur == IDX_W'(IDX + 1));

    // Hold counter and ready bit; tick, delay load and count changes update them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_ready <= 1'b0;
        end else if (i_ctrl.cfg_wr) begin
            r_ready <= (r_ready & i_act_new) | (i_act_new & ~i_act);
        end else if (i_ctrl.load && w_sel) begin
            r_cnt   <= i_ticks;
            r_ready <= 1'b0;
        end else if (i_ctrl.tick && i_act && (r_cnt != '0)) begin
            r_cnt <= r_cnt - TIMEOUT_WIDTH'(1);
            if (r_cnt == TIMEOUT_WIDTH'(1)) begin
                r_ready <= 1'b1;
            end
        end
    end

    // Request lines: any ready active thread, and those after the current one
    assign w_req_all = r_ready & i_act;
    assign w_req_up  = w_req_all & (IDX_W'(IDX) >= i_cur);

    // Pass the chain: the first requester in the group wins
    assign o_hit_all  = w_req_all & ~i_seen_all;
    assign o_hit_up   = w_req_up & ~i_seen_up;
    assign o_seen_all = i_seen_all | w_req_all;
    assign o_seen_up  = i_seen_up | w_req_up;
    assign o_ready    = r_ready;

endmodule
`default_nettype wire

FILE: hw/rtl/rrts_pick.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_pick
// Registers the per-group winners of the cell row and merges the groups
// into the index of the next thread.
// ----------------------------------------------------------------------------
module rrts_pick #(
    parameter int MAX_THREADS = 32
) (
    input  wire                       i_clk,
    input  wire                       i_capture,
    input  wire [MAX_THREADS-1:0]     i_hit_up,
    input  wire [MAX_THREADS-1:0]     i_hit_all,
    output logic [rrts_pkg::IDX_W-1:0] o_next,
    output logic                      o_any
);
    import rrts_pkg::*;

    localparam int NG = (MAX_THREADS + GROUP_SIZE - 1) / GROUP_SIZE;

    logic [MAX_THREADS-1:0] r_hit_up;
    logic [MAX_THREADS-1:0] r_hit_all;
    logic [NG-1:0]          w_gany_up;
    logic [NG-1:0]          w_gany_all;
    logic [NG-1:0]          w_gany;
    logic [NG-1:0]          w_gfirst;
    logic [MAX_THREADS-1:0] w_vec;
    logic [MAX_THREADS-1:0] w_sel;
    logic                   w_use_up;
    logic                   w_found;

    // Hold the chain results for the merge stage
    always_ff @(posedge i_clk) begin
        if (i_capture) begin
            r_hit_up  <= i_hit_up;
            r_hit_all <= i_hit_all;
        end
    end

    // Merge groups: prefer threads after the current one, else wrap
    always_comb begin
        w_gany_up  = '0;
        w_gany_all = '0;
        for (int i = 0; i < MAX_THREADS; i++) begin
            w_gany_up[i / GROUP_SIZE]  = w_gany_up[i / GROUP_SIZE] | r_hit_up[i];
            w_gany_all[i / GROUP_SIZE] = w_gany_all[i / GROUP_SIZE] | r_hit_all[i];
        end
        w_use_up = |w_gany_up;
        w_vec    = w_use_up ? r_hit_up : r_hit_all;
        w_gany   = w_use_up ? w_gany_up : w_gany_all;
        w_found  = 1'b0;
        for (int g = 0; g < NG; g++) begin
            w_gfirst[g] = w_gany[g] & ~w_found;
            w_found     = w_found | w_gany[g];
        end
        o_next = '0;
        for (int i = 0; i < MAX_THREADS; i++) begin
            w_sel[i] = w_vec[i] & w_gfirst[i / GROUP_SIZE];
            if (w_sel[i]) begin
                o_next = o_next | IDX_W'(i + 1);
            end
        end
        o_any = |w_gany_all;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/round_robin_thread_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler
// Round-robin thread scheduler with per-thread tick timeouts, built as a row
// of thread cells with a registered two-level pick of the next thread.
// ----------------------------------------------------------------------------
// Sequence: after acceptance the block passes through the scan state, the pick
//   state for schedule and for a delay from a user thread, and the output state,
//   where the result is loaded once the previous result is taken or gone.
// Throughput: one transaction at a time; the input is ready only in the idle
//   state, so a new operation waits for the cell update, the registered
//   in-group chain, the group merge stage when run, and the output load of the last one.
// Reset: synchronous; thread count 1, idle thread current, all timeouts and
//   ready bits cleared, no output pending.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler #(
    parameter int MAX_THREADS   = 32,
    parameter int TIMEOUT_WIDTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration
    input  wire         i_cfg_wr_en,
    input  wire  [5:0]  i_cfg_wr_data,  // thread_count
    // input stream
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [31:0] i_s_axis_tdata, // [31:0] delay_ticks
    input  wire  [1:0]  i_s_axis_tuser, // [1:0] op
    // output stream
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata  // [5:0] next_thread, [6] switch_request,
                                        // [38:7] ready_flags, [39] delay_error
);
    import rrts_pkg::*;

    localparam int MAX_USERS = MAX_THREADS;

    t_state               r_state;
    t_state               n_state;
    logic [TC_W-1:0]      r_tc;
    logic [IDX_W-1:0]     r_cur;
    logic [IDX_W-1:0]     r_before;
    logic                 r_err;
    logic                 r_sched;
    logic                 r_out_valid;
    logic [39:0]          r_out_data;

    logic                 w_accept;
    logic                 w_load_out;
    t_op                  w_op;
    t_cell_ctrl           w_ctrl;
    logic [IDX_W-1:0]     w_users_old;
    logic [IDX_W-1:0]     w_users_new;
    logic [IDX_W-1:0]     w_next;
    logic                 w_any;
    logic [MAX_THREADS-1:0] w_act;
    logic [MAX_THREADS-1:0] w_act_new;
    logic [MAX_THREADS-1:0] w_seen_up;
    logic [MAX_THREADS-1:0] w_seen_all;
    logic [MAX_THREADS-1:0] w_hit_up;
    logic [MAX_THREADS-1:0] w_hit_all;
    logic [MAX_THREADS-1:0] w_ready;
    logic [FLAGS_W-1:0]   w_flags;

    // Number of user threads from a thread count value
    function automatic logic [IDX_W-1:0] users_of(input logic [TC_W-1:0] tc);
        logic [IDX_W-1:0] u;
        if (tc == '0) begin
            u = '0;
        end else if (tc > TC_W'(MAX_USERS + 1)) begin
            u = IDX_W'(MAX_USERS);
        end else begin
            u = IDX_W'(tc - TC_W'(1));
        end
        return u;
    endfunction

    assign w_op        = t_op'(i_s_axis_tuser);
    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_users_old = users_of(r_tc);
    assign w_users_new = users_of(i_cfg_wr_data);

    // Broadcast commands to the cells
    always_comb begin
        w_ctrl.tick   = w_accept && (w_op == OP_TICK);
        w_ctrl.load   = w_accept && (w_op == OP_DELAY) && (r_cur != '0);
        w_ctrl.cfg_wr = i_cfg_wr_en;
    end

    // Row of thread cells; the priority chain restarts at each group
    genvar gi;
    generate
        for (gi = 0; gi < MAX_THREADS; gi++) begin : g_cell
            logic w_in_up;
            logic w_in_all;
            assign w_act[gi]     = (IDX_W'(gi) < w_users_old);
            assign w_act_new[gi] = (IDX_W'(gi) < w_users_new);
            if ((gi % GROUP_SIZE) == 0) begin : g_head
                assign w_in_up  = 1'b0;
                assign w_in_all = 1'b0;
            end else begin : g_link
                assign w_in_up  = w_seen_up[gi-1];
                assign w_in_all = w_seen_all[gi-1];
            end
            rrts_cell #(
                .IDX           (gi),
                .TIMEOUT_WIDTH (TIMEOUT_WIDTH)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (w_ctrl),
                .i_ticks    (i_s_axis_tdata[TIMEOUT_WIDTH-1:0]),
                .i_cur      (r_cur),
                .i_act      (w_act[gi]),
                .i_act_new  (w_act_new[gi]),
                .i_seen_up  (w_in_up),
                .i_seen_all (w_in_all),
                .o_seen_up  (w_seen_up[gi]),
                .o_seen_all (w_seen_all[gi]),
                .o_hit_up   (w_hit_up[gi]),
                .o_hit_all  (w_hit_all[gi]),
                .o_ready    (w_ready[gi])
            );
        end
    endgenerate

    // Merge the group winners into the next thread index
    rrts_pick #(
        .MAX_THREADS (MAX_THREADS)
    ) u_pick (
        .i_clk     (i_clk),
        .i_capture (r_state == S_SCAN),
        .i_hit_up  (w_hit_up),
        .i_hit_all (w_hit_all),
        .o_next    (w_next),
        .o_any     (w_any)
    );

    assign w_flags = FLAGS_W'(w_ready);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and handshake
    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        w_load_out      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_state = r_sched ? S_PICK : S_OUT;
            end
            S_PICK: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold thread count, current thread and transaction flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc    <= TC_W'(1);
            r_cur   <= '0;
            r_err   <= 1'b0;
            r_sched <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tc <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_err   <= (w_op == OP_DELAY) && (r_cur == '0);
                r_sched <= (w_op == OP_SCHED) || ((w_op == OP_DELAY) && (r_cur != '0));
            end
            if (r_state == S_PICK) begin
                r_cur <= w_any ? w_next : '0;
            end
        end
    end

    // Capture the thread current before the transaction
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_before <= r_cur;
        end
    end

    // Output register: load the result, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= {r_err, w_flags, (r_cur != r_before), r_cur};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the round-robin thread scheduler. A clocked driver
// feeds tick, schedule and delay operations from a queue, an operation-level
// scheduler model predicts each result at the moment its operation is taken,
// and a clocked monitor compares every returned result against the oldest
// prediction. Phases change the thread count and the idle pattern of both
// stream sides, and one phase holds the output back long enough to stall the
// input.
// ----------------------------------------------------------------------------
module testbench;
    import rrts_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 8;

    typedef struct {
        t_op         op;
        logic [31:0] ticks;
    } t_sched_op;

    typedef struct {
        logic [5:0]  next_thread;
        logic        switch_request;
        logic [31:0] ready_flags;
        logic        delay_error;
    } t_sched_result;

    typedef enum {
        PACE_FULL,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } t_pace;

    // DUT inputs, known from time zero
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_wr_en     = 1'b0;
    logic [5:0]  i_cfg_wr_data   = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [31:0] i_s_axis_tdata  = '0;
    logic [1:0]  i_s_axis_tuser  = '0;
    logic        i_m_axis_tready = 1'b1;

    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [39:0] o_m_axis_tdata;

    // Scheduler model state
    logic [5:0]  cur_thread;
    logic [31:0] ready_set;
    logic [31:0] timeouts [32];
    logic [5:0]  thread_cnt;

    t_sched_op     pending_ops[$];
    t_sched_result expected_results[$];
    t_sched_op     offer;
    t_sched_result predicted;
    t_sched_result oldest;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int fails          = 0;
    int cycles         = 0;

    round_robin_thread_scheduler dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Generate the clock
    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Effective thread count, clamped to 1 .. 33
    function automatic int active_count();
        int c;
        c = thread_cnt;
        if (c < 1) c = 1;
        if (c > 33) c = 33;
        return c;
    endfunction

    function automatic logic [31:0] active_mask();
        logic [63:0] m;
        m = (64'd1 << (active_count() - 1)) - 64'd1;
        return m[31:0];
    endfunction

    // Move to the next ready thread after the current one, or to idle
    task automatic pick_next_thread();
        int          cnt;
        int          idx;
        logic [31:0] ready;
        cnt   = active_count();
        ready = ready_set & active_mask();
        idx   = cur_thread;
        if (ready == '0) begin
            cur_thread = '0;
        end else begin
            for (int k = 0; k < cnt; k++) begin
                idx = idx + 1;
                if (idx >= cnt) idx = 1;
                if (ready[(idx - 1) & 31]) break;
            end
            cur_thread = idx[5:0];
        end
    endtask

    // Apply one operation to the model and form the result it yields
    task automatic advance_scheduler(input t_op op, input logic [31:0] ticks,
                                     output t_sched_result res);
        logic [5:0] prior;
        logic       err;
        int         slot;
        prior = cur_thread;
        err   = 1'b0;
        case (op)
            OP_TICK: begin
                for (int n = 1; n < active_count(); n++) begin
                    if (timeouts[n - 1] != '0) begin
                        timeouts[n - 1] = timeouts[n - 1] - 32'd1;
                        if (timeouts[n - 1] == '0) ready_set[n - 1] = 1'b1;
                    end
                end
            end
            OP_SCHED: begin
                pick_next_thread();
            end
            OP_DELAY: begin
                if (cur_thread == '0) begin
                    err = 1'b1;
                end else begin
                    slot = (cur_thread - 1) & 31;
                    timeouts[slot]  = ticks;
                    ready_set[slot] = 1'b0;
                    pick_next_thread();
                end
            end
            default: ;
        endcase
        res.next_thread    = cur_thread;
        res.switch_request = (cur_thread != prior);
        res.ready_flags    = ready_set;
        res.delay_error    = err;
    endtask

    // Write the thread count while the block is idle
    task automatic write_thread_count(input logic [5:0] value);
        logic [31:0] old_m;
        logic [31:0] new_m;
        old_m      = active_mask();
        thread_cnt = value;
        new_m      = active_mask();
        ready_set  = (ready_set & new_m) | (new_m & ~old_m);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic push_op(input t_op op, input logic [31:0] ticks);
        t_sched_op item;
        item.op    = op;
        item.ticks = ticks;
        pending_ops.push_back(item);
    endtask

    // Mostly short delays so threads come back; a few zero, huge or full-range
    task automatic push_random_op();
        int          r;
        logic [31:0] ticks;
        r = $urandom_range(99);
        if (r < 4) ticks = '0;
        else if (r < 10) ticks = $urandom;
        else if (r < 12) ticks = 32'hFFFF_FFFF;
        else ticks = $urandom_range(6, 1);
        r = $urandom_range(99);
        if (r < 35) push_op(OP_TICK, ticks);
        else if (r < 65) push_op(OP_SCHED, ticks);
        else push_op(OP_DELAY, ticks);
    endtask

    // Wait until every operation is sent and every result is back
    task automatic wait_drained();
        while (pending_ops.size() != 0 || i_s_axis_tvalid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic set_pace(input t_pace pace);
        case (pace)
            PACE_FULL:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            PACE_SEND_IDLE:  begin send_idle_pct = 76; recv_stall_pct = 0;  end
            PACE_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 76; end
            default:         begin send_idle_pct = 23; recv_stall_pct = 23; end
        endcase
    endtask

    task automatic run_random_phase(input logic [5:0] count, input t_pace pace,
                                    input int hold);
        wait_drained();
        write_thread_count(count);
        set_pace(pace);
        hold_left = hold;
        repeat (50) push_random_op();
    endtask

    // Driver: present queued operations, hold each until it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                advance_scheduler(t_op'(i_s_axis_tuser), i_s_axis_tdata, predicted);
                expected_results.push_back(predicted);
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offer = pending_ops.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= offer.ticks;
                    i_s_axis_tuser  <= offer.op;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
            fails = fails + 1;
        end
    endtask

    // Monitor: check each result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("result with no expectation waiting: %h", o_m_axis_tdata);
                fails = fails + 1;
            end else begin
                oldest = expected_results.pop_front();
                check_field("next_thread", 32'(oldest.next_thread),
                            32'(o_m_axis_tdata[5:0]));
                check_field("switch_request", 32'(oldest.switch_request),
                            32'(o_m_axis_tdata[6]));
                check_field("ready_flags", oldest.ready_flags, o_m_axis_tdata[38:7]);
                check_field("delay_error", 32'(oldest.delay_error),
                            32'(o_m_axis_tdata[39]));
            end
        end
    end

    // Receiver: count down a long hold, otherwise stall at random
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Sequence the run
    initial begin
        cur_thread = '0;
        thread_cnt = 6'd1;
        ready_set  = '0;
        foreach (timeouts[i]) timeouts[i] = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Single-thread setup: nothing ready, delay from idle is refused
        push_op(OP_SCHED, 32'd0);
        push_op(OP_DELAY, 32'd5);
        push_op(OP_TICK, 32'hFFFF_FFFF);
        push_op(OP_DELAY, 32'd0);

        // Full thread set: long park, block forever, short waits, wrap
        wait_drained();
        write_thread_count(6'd33);
        push_op(OP_SCHED, 32'd0);
        push_op(OP_DELAY, 32'hFFFF_FFFF);
        push_op(OP_DELAY, 32'd0);
        push_op(OP_DELAY, 32'd1);
        push_op(OP_TICK, 32'd0);
        push_op(OP_SCHED, 32'd0);
        push_op(OP_DELAY, 32'd2);
        push_op(OP_TICK, 32'd0);
        push_op(OP_TICK, 32'd0);
        push_op(OP_SCHED, 32'hA5A5_5A5A);
        push_op(OP_DELAY, 32'h5A5A_A5A5);
        repeat (8) push_op(OP_SCHED, 32'd0);

        // Shrink below the current thread, then search from outside the set
        wait_drained();
        write_thread_count(6'd3);
        push_op(OP_SCHED, 32'd0);
        push_op(OP_DELAY, 32'd1);
        push_op(OP_TICK, 32'd0);

        run_random_phase(6'd33, PACE_FULL, 0);
        run_random_phase(6'd5, PACE_SEND_IDLE, 0);
        run_random_phase(6'd17, PACE_RECV_STALL, 0);
        run_random_phase(6'd1, PACE_BOTH, 0);
        run_random_phase(6'd2, PACE_FULL, 0);
        run_random_phase(6'd33, PACE_RECV_STALL, 0);
        run_random_phase(6'd9, PACE_BOTH, 0);
        run_random_phase(6'd32, PACE_SEND_IDLE, 0);
        run_random_phase(6'd3, PACE_FULL, 400);
        run_random_phase(6'd33, PACE_BOTH, 0);
        run_random_phase(6'd12, PACE_RECV_STALL, 0);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
